### rtl/core/pcg32_random_generator_defines.svh
// ----------------------------------------------------------------------------
// PCG32 generator assertion macros
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PCG32_RANDOM_GENERATOR_DEFINES_SVH
`define PCG32_RANDOM_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/pcg32_pkg.sv
// ----------------------------------------------------------------------------
// PCG32 generator package
// Constants, sequencer states and the XSH-RR output function.
// ----------------------------------------------------------------------------
package pcg32_pkg;

	localparam logic [1:0] CMD_RESEED  = 2'd0;
	localparam logic [1:0] CMD_RAW     = 2'd1;
	localparam logic [1:0] CMD_BOUNDED = 2'd2;

	localparam logic [63:0] PCG_MULT   = 64'h5851_F42D_4C95_7F2D;
	localparam logic [63:0] PCG_INC    = 64'h1405_7B7E_F767_814F;
	localparam logic [63:0] RESET_SEED = 64'h0000_0000_4F6C_DD1F;

	// State after the add of a reseed, before its final step.
	localparam logic [63:0] INIT_STATE = PCG_INC + RESET_SEED;

	localparam int XS_SHIFT_A = 18;
	localparam int XS_SHIFT_B = 27;
	localparam int ROT_SHIFT  = 59;

	// The 64-bit product is built from three 32x32 partial products.
	localparam logic [1:0] MUL_LAST = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAW,
		ST_MUL,
		ST_THR,
		ST_MOD,
		ST_DONE
	} state_t;

	function automatic logic [31:0] pcg_output(input logic [63:0] s);
		logic [63:0] xs_wide;
		logic [31:0] xs;
		logic [4:0]  rot;
		logic [63:0] rotated;
		xs_wide = ((s >> XS_SHIFT_A) ^ s) >> XS_SHIFT_B;
		xs      = xs_wide[31:0];
		rot     = 5'(s >> ROT_SHIFT);
		rotated = {xs, xs} >> rot;
		return rotated[31:0];
	endfunction

endpackage

### rtl/core/pcg32_random_generator.sv
// ----------------------------------------------------------------------------
// PCG32 random generator
// 64-bit LCG with XSH-RR output, reseed, raw and bounded draws.
// ----------------------------------------------------------------------------
// A request carries cmd, seed_value and bound on a valid/ready channel; every
// request gives exactly one result (value, bad_bound) on a valid/ready output
// channel. One request is worked on at a time and in_ready is high only while
// the sequencer is idle.
// The state step uses one shared 32x32 multiplier for all of its partial products. The
// remainder unit is a restoring divider that retires one bit per cycle.
// Path from the request to the loaded result register:
//   reseed and raw draw: the multiplier steps, then the result state.
//   bounded draw: threshold remainder, draw and state step, final remainder;
//   every rejected word adds another draw and state step.
//   bound of zero or unused command: straight to the result state.
// The next request is taken in the cycle after a result is loaded, so
// requests never overlap in the sequencer.
// After reset the block seeds itself with the built-in seed, with in_ready low
// until that is done. The result register frees the work side from
// the receiver: a finished result waits there while out_ready is low, and
// a new result is held back only while that register is still occupied.
// ----------------------------------------------------------------------------
`include "pcg32_random_generator_defines.svh"

module pcg32_random_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [63:0] seed_value,
	input  logic [31:0] bound,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value,
	output logic        bad_bound
);
	import pcg32_pkg::*;

	state_t      state_q, state_d;
	logic        init_q;
	logic [1:0]  op_q;
	logic [31:0] bound_q;
	logic [63:0] lcg_q;
	logic [63:0] acc_q;
	logic [1:0]  mph_q;
	logic [31:0] word_q;
	logic [31:0] thr_q;
	logic [31:0] num_q;
	logic [31:0] rem_q;
	logic [4:0]  dcnt_q;
	logic [31:0] res_val_q;
	logic        res_bad_q;
	logic        out_valid_q;
	logic [31:0] value_q;
	logic        bad_q;

	logic        accept;
	logic        out_load;
	logic        mul_done;
	logic        div_done;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [63:0] acc_next;
	logic [32:0] div_try;
	logic [33:0] div_diff;
	logic [31:0] rem_next;

	// Shared multiplier: low x low, then both cross terms into the upper half.
	always_comb begin
		mul_a = (mph_q == 2'd1) ? lcg_q[63:32] : lcg_q[31:0];
		mul_b = (mph_q == MUL_LAST) ? PCG_MULT[63:32] : PCG_MULT[31:0];
		prod  = 64'(mul_a) * 64'(mul_b);
		if (mph_q == 2'd0) begin
			acc_next = prod + PCG_INC;
		end else begin
			acc_next = acc_q + {prod[31:0], 32'd0};
		end
	end

	// Restoring divider step; only the remainder is kept.
	always_comb begin
		div_try  = {rem_q, num_q[31]};
		div_diff = {1'b0, div_try} - {2'b00, bound_q};
		rem_next = div_diff[33] ? div_try[31:0] : div_diff[31:0];
	end

	assign mul_done = (state_q == ST_MUL) && (mph_q == MUL_LAST);
	assign div_done = (dcnt_q == 5'd31);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MUL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (cmd)
						CMD_RESEED, CMD_RAW: state_d = ST_MUL;
						CMD_BOUNDED: state_d = (bound == 32'd0) ? ST_DONE : ST_THR;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_DRAW: state_d = ST_MUL;
			ST_MUL: begin
				if (mul_done) begin
					if (init_q) begin
						state_d = ST_IDLE;
					end else if (op_q == CMD_BOUNDED) begin
						state_d = (word_q >= thr_q) ? ST_MOD : ST_DRAW;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_THR: if (div_done) state_d = ST_DRAW;
			ST_MOD: if (div_done) state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= 1'b1;
			mph_q       <= 2'd0;
			dcnt_q      <= 5'd0;
			out_valid_q <= 1'b0;
			lcg_q       <= INIT_STATE;
		end else begin
			if (mul_done) begin
				init_q <= 1'b0;
				lcg_q  <= acc_next;
			end else if (accept && cmd == CMD_RESEED) begin
				lcg_q <= PCG_INC + seed_value;
			end

			if (state_q == ST_MUL) begin
				mph_q <= mul_done ? 2'd0 : mph_q + 2'd1;
			end

			if (state_q == ST_THR || state_q == ST_MOD) begin
				dcnt_q <= dcnt_q + 5'd1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			acc_q <= acc_next;
		end

		if (accept) begin
			op_q      <= cmd;
			bound_q   <= bound;
			res_val_q <= 32'd0;
			res_bad_q <= (cmd == CMD_BOUNDED) && (bound == 32'd0);
			word_q    <= pcg_output(lcg_q);
			num_q     <= 32'd0 - bound;
			rem_q     <= 32'd0;
		end else if (state_q == ST_DRAW) begin
			word_q <= pcg_output(lcg_q);
		end else if (state_q == ST_THR || state_q == ST_MOD) begin
			num_q <= {num_q[30:0], 1'b0};
			rem_q <= rem_next;
			if (div_done && state_q == ST_THR) begin
				thr_q <= rem_next;
			end
			if (div_done && state_q == ST_MOD) begin
				res_val_q <= rem_next;
			end
		end else if (mul_done) begin
			if (op_q == CMD_RAW) begin
				res_val_q <= word_q;
			end
			num_q <= word_q;
			rem_q <= 32'd0;
		end

		if (out_load) begin
			value_q <= res_val_q;
			bad_q   <= res_bad_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign bad_bound = bad_q;

	`PCG_ASSERT_NOW(a_bad_gives_zero, out_valid && bad_bound, value == 32'd0,
		"bad_bound result with nonzero value")
	`PCG_ASSERT_NEXT(a_zero_bound_keeps_state,
		accept && cmd == CMD_BOUNDED && bound == 32'd0, $stable(lcg_q),
		"zero bound request changed the generator state")
	`PCG_ASSERT_NOW(a_rem_below_bound, state_q == ST_THR || state_q == ST_MOD,
		rem_q < bound_q, "divider remainder reached the bound")
	`PCG_ASSERT_NOW(a_mul_phase_range, 1'b1, mph_q <= MUL_LAST,
		"multiplier phase out of range")

endmodule

### tb/sv/pcg32_random_generator_tb.sv
// ----------------------------------------------------------------------------
// PCG32 random generator testbench
// Sends reseed, raw, bounded and unused requests through the request channel
// with random gaps and output stalls, predicts every result with a bit-exact
// model of the LCG and the XSH-RR output, and checks each result in order.
// ----------------------------------------------------------------------------
module pcg32_random_generator_tb;

	import pcg32_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 600;
	localparam int DRAIN_CYCLES = 100;
	localparam int TIMEOUT_CYCLES = 1000000;

	typedef struct {
		logic [31:0] word;
		logic        bad_bound;
	} draw_result_t;

	// Keeps its own copy of the generator state and the queue of results
	// that accepted requests still owe.
	class draw_checker;
		logic [63:0]  lcg;
		draw_result_t owed_q[$];
		int errors;
		int n_reseed;
		int n_raw;
		int n_bounded;
		int n_zero;
		int n_unused;
		int n_checked;

		function new();
			errors = 0;
			n_reseed = 0;
			n_raw = 0;
			n_bounded = 0;
			n_zero = 0;
			n_unused = 0;
			n_checked = 0;
			reseed(RESET_SEED);
		endfunction

		function void advance();
			lcg = lcg * PCG_MULT + PCG_INC;
		endfunction

		function void reseed(input logic [63:0] s);
			lcg = '0;
			advance();
			lcg = lcg + s;
			advance();
		endfunction

		// The output word comes from the state before the step.
		function logic [31:0] next_word();
			logic [63:0] old;
			logic [31:0] xs;
			int rot;
			old = lcg;
			advance();
			xs = 32'(((old >> XS_SHIFT_A) ^ old) >> XS_SHIFT_B);
			rot = int'(old >> ROT_SHIFT) & 31;
			return (xs >> rot) | (xs << ((32 - rot) & 31));
		endfunction

		function void note_request(input logic [1:0] c, input logic [63:0] s,
			input logic [31:0] b);
			draw_result_t r;
			logic [31:0] thr;
			logic [31:0] w;
			r.word = '0;
			r.bad_bound = 1'b0;
			case (c)
				CMD_RESEED: begin
					reseed(s);
					n_reseed++;
				end
				CMD_RAW: begin
					r.word = next_word();
					n_raw++;
				end
				CMD_BOUNDED: begin
					n_bounded++;
					if (b == '0) begin
						r.bad_bound = 1'b1;
						n_zero++;
					end else begin
						// Words below 2^32 mod n are rejected to keep the result unbiased.
						thr = (32'd0 - b) % b;
						do
							w = next_word();
						while (w < thr);
						r.word = w % b;
					end
				end
				default: begin
					n_unused++;
				end
			endcase
			owed_q.push_back(r);
		endfunction

		function void check_result(input logic [31:0] v, input logic bb);
			draw_result_t e;
			if (owed_q.size() == 0) begin
				$error("result with no request outstanding: value %h bad_bound %b", v, bb);
				errors++;
				return;
			end
			e = owed_q.pop_front();
			n_checked++;
			if (v !== e.word) begin
				$error("value: expected %h, actual %h", e.word, v);
				errors++;
			end
			if (bb !== e.bad_bound) begin
				$error("bad_bound: expected %b, actual %b", e.bad_bound, bb);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [63:0] seed_value;
	logic [31:0] bound;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] value;
	logic        bad_bound;

	draw_checker checker_h;
	bit calm;
	int cycles;

	pcg32_random_generator i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.seed_value (seed_value),
		.bound      (bound),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.bad_bound  (bad_bound)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= TIMEOUT_CYCLES) begin
			$display("pcg32_random_generator_tb: errors");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one; none at all in calm stretches.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 65)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_bound();
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2, 3: return $urandom_range(1, 16);
			4, 5: return $urandom;
			6: return 32'd1 << $urandom_range(0, 31);
			7: return 32'h8000_0000 + $urandom_range(0, 255);
			8: return 32'hFFFF_FFFF - $urandom_range(0, 255);
			default: return 32'h7FFF_FFFF - $urandom_range(0, 255);
		endcase
	endfunction

	function automatic logic [63:0] pick_seed();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Presents one request and returns after the edge at which it is taken.
	task automatic send_request(input logic [1:0] c, input logic [63:0] s,
		input logic [31:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		seed_value <= s;
		bound      <= b;
		do
			@(posedge clk);
		while (!in_ready);
		checker_h.note_request(c, s, b);
	endtask

	// Result side: check on every handshake, then pick the next ready level.
	initial begin : result_side
		int stall;
		stall = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				checker_h.check_result(value, bad_bound);
			if (calm) begin
				out_ready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				stall = pick_gap();
				out_ready <= (stall == 0);
			end
		end
	end

	initial begin : request_side
		int counted;
		int roll;
		logic [1:0] c;
		checker_h = new();
		cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_RESEED;
		seed_value = '0;
		bound = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: first words after the built-in seed, bound extremes,
		// zero and one bounds, heavy rejection, unused command and reseeds.
		send_request(CMD_RAW, '0, '0);
		send_request(CMD_RAW, '1, '1);
		send_request(CMD_BOUNDED, '0, 32'd1);
		send_request(CMD_BOUNDED, '1, 32'd0);
		send_request(CMD_BOUNDED, '0, 32'd2);
		send_request(CMD_BOUNDED, '0, 32'hFFFF_FFFF);
		send_request(CMD_BOUNDED, '0, 32'h8000_0001);
		send_request(CMD_BOUNDED, '0, 32'h8000_0000);
		send_request(CMD_BOUNDED, '0, 32'd3);
		send_request(CMD_UNUSED, '1, '1);
		send_request(CMD_RAW, '0, '0);
		send_request(CMD_RESEED, '0, '0);
		send_request(CMD_RAW, '0, '0);
		send_request(CMD_BOUNDED, '0, 32'd10);
		send_request(CMD_RESEED, '1, '1);
		send_request(CMD_RAW, '0, '0);
		send_request(CMD_RAW, '0, '0);
		send_request(CMD_RESEED, RESET_SEED, '0);
		send_request(CMD_RAW, '0, '0);
		send_request(CMD_BOUNDED, '0, 32'h7FFF_FFFF);
		send_request(CMD_UNUSED, '0, '0);
		send_request(CMD_BOUNDED, '0, 32'd6);

		counted = 0;
		while (counted < RANDOM_REQUESTS) begin
			if (counted % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 10)
				c = CMD_RESEED;
			else if (roll < 45)
				c = CMD_RAW;
			else if (roll < 95)
				c = CMD_BOUNDED;
			else
				c = CMD_UNUSED;
			if (c != CMD_UNUSED)
				counted++;
			send_request(c, pick_seed(), pick_bound());
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (checker_h.owed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d reseeds, %0d raw draws, %0d bounded draws (%0d with zero bound)",
			checker_h.n_reseed, checker_h.n_raw, checker_h.n_bounded, checker_h.n_zero);
		$display("and %0d unused commands; %0d results checked, %0d mismatches.",
			checker_h.n_unused, checker_h.n_checked, checker_h.errors);
		if (checker_h.errors == 0)
			$display("pcg32_random_generator_tb: clean");
		else
			$display("pcg32_random_generator_tb: errors");
		$finish;
	end

endmodule
